// ===== src/k_queues_shared_store_assert.svh =====
// Assertion macros for the shared queue store.
`ifndef K_QUEUES_SHARED_STORE_ASSERT_SVH
`define K_QUEUES_SHARED_STORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KQSS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kqss: implication failed");

// Next-cycle implication, sampled on clk, off during reset.
`define KQSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kqss: next-cycle implication failed");

`endif

// ===== src/kqss_pkg.sv =====
`default_nettype none

package kqss_pkg;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== src/k_queues_shared_store.sv =====
`default_nettype none

// NUM_QUEUES FIFO queues sharing one store of CAPACITY entries. Pulse start
// with action, queue_id and data_in while busy is low; the item transfers at
// that edge. Exactly one result follows: done is high for one cycle with
// data_out and status, and the receiver cannot stall it, so capture it then.
// An enqueue passes through S_ENQ; a dequeue through S_DEQ_Q and, unless the
// queue is empty, S_DEQ_E: the queue table read and then the entry store read
// are registered. A new item may start in the cycle that done is high.
// No clearing pass runs after reset; the block takes items at once.
module k_queues_shared_store #(
    parameter int CAPACITY   = 64,
    parameter int NUM_QUEUES = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               action,
    input  logic [1:0]         queue_id,
    input  logic signed [31:0] data_in,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] data_out,
    output logic [1:0]         status
);
    import kqss_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ENQ   = 4'b0010,
        S_DEQ_Q = 4'b0100,
        S_DEQ_E = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] fresh_reg, fresh_next;
    logic [NUM_QUEUES-1:0] qvalid_reg, qvalid_next;
    logic done_reg, done_next;
    logic signed [31:0] dout_reg, dout_next;
    logic [1:0] status_reg, status_next;

    logic [QW-1:0] q_reg;
    logic bad_reg;
    logic signed [31:0] din_reg;

    logic [LW-1:0] link_mem [CAPACITY];
    logic [31:0] data_mem [CAPACITY];
    logic [2*LW-1:0] queue_mem [NUM_QUEUES];
    logic [LW-1:0] link_rd_reg;
    logic [31:0] data_rd_reg;
    logic [2*LW-1:0] queue_rd_reg;

    logic accept;
    logic [QW-1:0] qidx;
    logic e_rd_en;
    logic [AW-1:0] e_rd_addr;
    logic lk_wr_en;
    logic [AW-1:0] lk_wr_addr;
    logic [LW-1:0] lk_wr_data;
    logic dt_wr_en;
    logic q_wr_en;
    logic [2*LW-1:0] q_wr_data;
    logic [LW-1:0] q_head, q_tail;
    logic q_live;
    logic slot_ok;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign data_out = dout_reg;
    assign status  = status_reg;

    assign qidx    = QW'(queue_id);
    assign q_head  = queue_rd_reg[2*LW-1:LW];
    assign q_tail  = queue_rd_reg[LW-1:0];
    assign q_live  = !bad_reg && qvalid_reg[q_reg];
    assign slot_ok = (free_head_reg < NIL);

    assign e_rd_en   = accept || (state_reg == S_DEQ_Q);
    assign e_rd_addr = (state_reg == S_DEQ_Q) ? q_head[AW-1:0] : free_head_reg[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        qvalid_next    = qvalid_reg;
        done_next      = 1'b0;
        dout_next      = dout_reg;
        status_next    = status_reg;
        lk_wr_en       = 1'b0;
        lk_wr_addr     = q_tail[AW-1:0];
        lk_wr_data     = free_head_reg;
        dt_wr_en       = 1'b0;
        q_wr_en        = 1'b0;
        q_wr_data      = {free_head_reg, free_head_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action == ACT_DEQ) ? S_DEQ_Q : S_ENQ;
                end
            end
            S_ENQ:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                dout_next  = '0;
                if (bad_reg || !slot_ok)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    status_next = STATUS_OK;
                    if (free_head_reg == fresh_reg)
                    begin
                        free_head_next = free_head_reg + LW'(1);
                        fresh_next     = fresh_reg + LW'(1);
                    end
                    else
                    begin
                        free_head_next = link_rd_reg;
                    end
                    dt_wr_en           = 1'b1;
                    q_wr_en            = 1'b1;
                    qvalid_next[q_reg] = 1'b1;
                    if (qvalid_reg[q_reg])
                    begin
                        q_wr_data  = {q_head, free_head_reg};
                        lk_wr_en   = 1'b1;
                        lk_wr_addr = q_tail[AW-1:0];
                        lk_wr_data = free_head_reg;
                    end
                end
            end
            S_DEQ_Q:
            begin
                if (!q_live)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    dout_next   = '0;
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    state_next = S_DEQ_E;
                end
            end
            S_DEQ_E:
            begin
                state_next     = S_IDLE;
                done_next      = 1'b1;
                dout_next      = data_rd_reg;
                status_next    = STATUS_OK;
                lk_wr_en       = 1'b1;
                lk_wr_addr     = q_head[AW-1:0];
                lk_wr_data     = free_head_reg;
                free_head_next = q_head;
                if (q_head == q_tail)
                begin
                    qvalid_next[q_reg] = 1'b0;
                end
                else
                begin
                    q_wr_en   = 1'b1;
                    q_wr_data = {link_rd_reg, q_tail};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            qvalid_reg    <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            qvalid_reg    <= qvalid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg   <= dout_next;
        status_reg <= status_next;
        if (accept)
        begin
            q_reg   <= qidx;
            bad_reg <= (32'(queue_id) >= NUM_QUEUES);
            din_reg <= data_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_rd_en)
        begin
            link_rd_reg <= link_mem[e_rd_addr];
            data_rd_reg <= data_mem[e_rd_addr];
        end
        if (lk_wr_en)
        begin
            link_mem[lk_wr_addr] <= lk_wr_data;
        end
        if (dt_wr_en)
        begin
            data_mem[free_head_reg[AW-1:0]] <= din_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_rd_reg <= queue_mem[qidx];
        end
        if (q_wr_en)
        begin
            queue_mem[q_reg] <= q_wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/kqss_checker.sv =====
`default_nettype none

`include "k_queues_shared_store_assert.svh"

module kqss_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               action,
    input wire logic [1:0]         queue_id,
    input wire logic signed [31:0] data_in,
    input wire logic               busy,
    input wire logic               done,
    input wire logic signed [31:0] data_out,
    input wire logic [1:0]         status
);
    import kqss_pkg::*;

    logic accept;
    assign accept = start && !busy;

    `KQSS_ASSERT_NEXT(a_busy_after_transfer, accept, busy)
    `KQSS_ASSERT_IMPL(a_done_when_idle, done, !busy && $past(busy))
    `KQSS_ASSERT_IMPL(a_fail_data_zero, done && (status != STATUS_OK), data_out == 32'sd0)
    `KQSS_ASSERT_IMPL(a_enq_two_cycles, accept && (action == ACT_ENQ),
                      ##2 (done && (data_out == 32'sd0)))
    `KQSS_ASSERT_IMPL(a_status_code, done,
                      (status == STATUS_OK) || (status == STATUS_FULL) ||
                      (status == STATUS_EMPTY))

endmodule

bind k_queues_shared_store kqss_checker u_kqss_checker (.*);

`default_nettype wire

// ===== tb/k_queues_shared_store_tb.sv =====
`timescale 1ns / 1ps

module k_queues_shared_store_tb;
    import kqss_pkg::*;

    localparam int CAPACITY = 64;
    localparam int NUM_QUEUES = 4;
    localparam logic [6:0] NIL_SLOT = 7'd64;
    localparam int RANDOM_ITEMS = 650;
    localparam int PHASE_LEN = 80;

    typedef struct {
        logic signed [31:0] data;
        logic [1:0]         status;
    } result_t;

    typedef struct {
        logic       act;
        logic [1:0] q;
        logic [31:0] d;
        bit         typed;
        result_t    res;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               action;
    logic [1:0]         queue_id;
    logic signed [31:0] data_in;
    logic               busy;
    logic               done;
    logic signed [31:0] data_out;
    logic [1:0]         status;

    logic [6:0]  head_ptr [NUM_QUEUES];
    logic [6:0]  tail_ptr [NUM_QUEUES];
    logic [6:0]  link_mem [CAPACITY];
    logic [31:0] entry_mem [CAPACITY];
    logic [6:0]  free_head;

    result_t pending_results[$];
    row_t    directed_rows[$];
    int      errors = 0;

    k_queues_shared_store #(
        .CAPACITY(CAPACITY),
        .NUM_QUEUES(NUM_QUEUES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .action(action),
        .queue_id(queue_id),
        .data_in(data_in),
        .busy(busy),
        .done(done),
        .data_out(data_out),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic bit is_slot(input logic [6:0] p);
        return p < CAPACITY;
    endfunction

    task automatic reset_store_model();
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            head_ptr[i] = NIL_SLOT;
            tail_ptr[i] = NIL_SLOT;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            link_mem[i] = 7'(i + 1);
            entry_mem[i] = '0;
        end
        link_mem[CAPACITY - 1] = NIL_SLOT;
        free_head = '0;
    endtask

    task automatic apply_queue_op(input logic act, input logic [1:0] q,
                                  input logic [31:0] d, output result_t r);
        logic [6:0] slot;
        logic [6:0] nxt;
        r.data = '0;
        r.status = STATUS_OK;
        if (q >= NUM_QUEUES)
        begin
            r.status = (act == ACT_DEQ) ? STATUS_EMPTY : STATUS_FULL;
        end
        else if (act == ACT_ENQ)
        begin
            slot = free_head;
            if (!is_slot(slot))
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                free_head = is_slot(link_mem[slot]) ? link_mem[slot] : NIL_SLOT;
                entry_mem[slot] = d;
                link_mem[slot] = NIL_SLOT;
                if (!is_slot(head_ptr[q]) || !is_slot(tail_ptr[q]))
                    head_ptr[q] = slot;
                else
                    link_mem[tail_ptr[q]] = slot;
                tail_ptr[q] = slot;
            end
        end
        else
        begin
            slot = head_ptr[q];
            if (!is_slot(slot))
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                r.data = entry_mem[slot];
                nxt = is_slot(link_mem[slot]) ? link_mem[slot] : NIL_SLOT;
                head_ptr[q] = nxt;
                if (!is_slot(nxt))
                    tail_ptr[q] = NIL_SLOT;
                link_mem[slot] = free_head;
                free_head = slot;
            end
        end
    endtask

    task automatic add_row(input logic act, input logic [1:0] q, input logic [31:0] d,
                           input bit typed, input logic [31:0] exp_data,
                           input logic [1:0] exp_status);
        row_t row;
        row.act = act;
        row.q = q;
        row.d = d;
        row.typed = typed;
        row.res.data = exp_data;
        row.res.status = exp_status;
        directed_rows.push_back(row);
    endtask

    // hold start high until the transfer, then record what the store should answer
    task automatic send_op(input row_t row);
        result_t r;
        @(negedge clk);
        start <= 1'b1;
        action <= row.act;
        queue_id <= row.q;
        data_in <= row.d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_queue_op(row.act, row.q, row.d, r);
        if (row.typed)
            r = row.res;
        pending_results.push_back(r);
    endtask

    task automatic maybe_idle(input bit allow);
        int n;
        if (allow && $urandom_range(99) < 23)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual data_out %h status %0d",
                         $time, data_out, status);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (data_out !== e.data)
                begin
                    $display("%0t: data_out mismatch expected %h actual %h",
                             $time, e.data, data_out);
                    errors++;
                end
                if (status !== e.status)
                begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, e.status, status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        row_t row;
        int phase;
        int enq_pct [4];
        enq_pct = '{88, 60, 12, 45};
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_ENQ;
        queue_id = '0;
        data_in = '0;
        reset_store_model();

        add_row(ACT_DEQ, 2'd0, 32'h0, 1, 32'h0, STATUS_EMPTY);
        add_row(ACT_DEQ, 2'd1, 32'hffffffff, 1, 32'h0, STATUS_EMPTY);
        add_row(ACT_DEQ, 2'd2, 32'h0, 1, 32'h0, STATUS_EMPTY);
        add_row(ACT_DEQ, 2'd3, 32'h0, 1, 32'h0, STATUS_EMPTY);
        add_row(ACT_ENQ, 2'd0, 32'h7fffffff, 1, 32'h0, STATUS_OK);
        add_row(ACT_ENQ, 2'd0, 32'h80000000, 1, 32'h0, STATUS_OK);
        add_row(ACT_ENQ, 2'd1, 32'hffffffff, 1, 32'h0, STATUS_OK);
        add_row(ACT_ENQ, 2'd2, 32'h00000000, 1, 32'h0, STATUS_OK);
        add_row(ACT_ENQ, 2'd3, 32'ha5a5a5a5, 1, 32'h0, STATUS_OK);
        add_row(ACT_ENQ, 2'd0, 32'h5a5a5a5a, 1, 32'h0, STATUS_OK);
        add_row(ACT_DEQ, 2'd0, 32'h0, 0, 32'h0, STATUS_OK);
        add_row(ACT_DEQ, 2'd1, 32'h0, 0, 32'h0, STATUS_OK);
        add_row(ACT_DEQ, 2'd1, 32'h0, 1, 32'h0, STATUS_EMPTY);
        add_row(ACT_ENQ, 2'd1, 32'h12345678, 1, 32'h0, STATUS_OK);
        add_row(ACT_ENQ, 2'd1, 32'hedcba987, 1, 32'h0, STATUS_OK);
        add_row(ACT_DEQ, 2'd1, 32'h0, 0, 32'h0, STATUS_OK);
        add_row(ACT_DEQ, 2'd0, 32'h0, 0, 32'h0, STATUS_OK);
        add_row(ACT_DEQ, 2'd0, 32'h0, 0, 32'h0, STATUS_OK);
        add_row(ACT_DEQ, 2'd0, 32'h0, 1, 32'h0, STATUS_EMPTY);
        add_row(ACT_DEQ, 2'd2, 32'h0, 0, 32'h0, STATUS_OK);
        add_row(ACT_DEQ, 2'd3, 32'h0, 0, 32'h0, STATUS_OK);
        add_row(ACT_DEQ, 2'd2, 32'h0, 1, 32'h0, STATUS_EMPTY);
        add_row(ACT_DEQ, 2'd1, 32'h0, 0, 32'h0, STATUS_OK);
        add_row(ACT_DEQ, 2'd1, 32'h0, 1, 32'h0, STATUS_EMPTY);

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            maybe_idle(1'b1);
            send_op(directed_rows[i]);
        end

        // alternate fill and drain phases so the store runs full and queues run dry
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            phase = (i / PHASE_LEN) % 4;
            row.act = ($urandom_range(99) < enq_pct[phase]) ? ACT_ENQ : ACT_DEQ;
            row.q = 2'($urandom_range(NUM_QUEUES - 1));
            row.d = $urandom;
            row.typed = 0;
            row.res.data = '0;
            row.res.status = STATUS_OK;
            maybe_idle(!(i >= 250 && i < 400));
            send_op(row);
        end

        @(negedge clk);
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
